FILE: rtl/core/modular_power_unit_assert.svh
// ----------------------------------------------------------------------------
// Modular power unit assertion macros
// Property wrappers clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MODULAR_POWER_UNIT_ASSERT_SVH
`define MODULAR_POWER_UNIT_ASSERT_SVH

// same-cycle implication
`define MPU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mpu_pkg.sv
// ----------------------------------------------------------------------------
// Modular power unit package
// Widths, modulus constants and sequencer types.
// ----------------------------------------------------------------------------
package mpu_pkg;

   localparam int EXP_BITS = 63;   // exponent bits processed (1..63)
   localparam int BASE_W   = 63;
   localparam int EXP_W    = 63;
   localparam int POWER_W  = 30;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 64;

   localparam logic [MUL_W-1:0] PRIME      = 32'd998244353;
   localparam logic [MUL_W-1:0] PRIME_X2   = 32'd1996488706;
   localparam logic [MUL_W-1:0] PRIME_X3   = 32'd2994733059;
   // 2^31 mod PRIME, folds the upper base bits
   localparam logic [MUL_W-1:0] FOLD_K     = 32'd150994942;
   // floor(2^60 / PRIME)
   localparam logic [MUL_W-1:0] BARRETT_MU = 32'd1154949187;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_ADD,
      ST_MUL,
      ST_BQ1,
      ST_BQ2,
      ST_BSUB,
      ST_BFIX,
      ST_BIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_FOLD,
      OP_MULT,
      OP_SQUARE
   } op_type;

endpackage

FILE: rtl/core/modular_power_unit.sv
// ----------------------------------------------------------------------------
// Modular power unit: base^exponent mod 998244353, square and multiply
// One request in flight; the next is taken in the idle cycle after the response loads.
// Rate is set by the single 32x32 multiplier, used three times per modmult.
// Synchronous active-high reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "modular_power_unit_assert.svh"

module modular_power_unit
   import mpu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [62:0] base, [125:63] exponent, rest zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // [29:0] power, rest zero
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [EXP_BITS-1:0] exp_ff;
   logic [BASE_W-1:0]   x_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [MUL_W-1:0]    r_ff;
   logic [POWER_W-1:0]  acc_ff;
   logic [POWER_W-1:0]  base_ff;
   logic                rsp_valid_ff;
   logic [POWER_W-1:0]  rsp_data_ff;

   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [PROD_W-1:0]   mul_prod;
   logic [POWER_W-1:0]  fix_val;
   logic                exp_more;
   logic                req_acc;
   logic                load_out;
   logic                shift_exp;

   assign exp_more = ((exp_ff >> 1) != '0);
   assign req_acc  = req_tvalid && req_tready;
   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FOLD;
               op_in    = OP_FOLD;
            end
         end
         ST_FOLD: state_in = ST_ADD;
         ST_ADD:  state_in = ST_BQ1;
         ST_MUL:  state_in = ST_BQ1;
         ST_BQ1:  state_in = ST_BQ2;
         ST_BQ2:  state_in = ST_BSUB;
         ST_BSUB: state_in = ST_BFIX;
         ST_BFIX: begin
            if (op_ff == OP_MULT && exp_more) begin
               state_in = ST_MUL;
               op_in    = OP_SQUARE;
            end else begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (exp_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
               op_in    = exp_ff[0] ? OP_MULT : OP_SQUARE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and shared multiplier operand select
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !reset;
      load_out   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
      shift_exp  = (state_ff == ST_BFIX) &&
                   ((op_ff == OP_SQUARE) || (op_ff == OP_MULT && !exp_more));
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         ST_FOLD: begin
            mul_a = x_ff[BASE_W-1:31];
            mul_b = FOLD_K;
         end
         ST_MUL: begin
            mul_a = {2'b00, (op_ff == OP_MULT) ? acc_ff : base_ff};
            mul_b = {2'b00, base_ff};
         end
         ST_BQ1: begin
            mul_a = {1'b0, prod_ff[59:29]};
            mul_b = BARRETT_MU;
         end
         ST_BQ2: begin
            mul_a = prod_ff[62:31];
            mul_b = PRIME;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Barrett remainder is below 3P: at most two corrections
   always_comb begin
      if (r_ff >= PRIME_X2) begin
         fix_val = POWER_W'(r_ff - PRIME_X2);
      end else if (r_ff >= PRIME) begin
         fix_val = POWER_W'(r_ff - PRIME);
      end else begin
         fix_val = r_ff[POWER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff   <= req_tdata[BASE_W-1:0];
         exp_ff <= req_tdata[BASE_W +: EXP_BITS];
         acc_ff <= POWER_W'(1);
      end
      case (state_ff)
         ST_FOLD, ST_MUL, ST_BQ2: prod_ff <= mul_prod;
         ST_BQ1: begin
            prod_ff <= mul_prod;
            x_ff    <= prod_ff[BASE_W-1:0];
         end
         ST_ADD:  prod_ff <= prod_ff + PROD_W'(x_ff[30:0]);
         ST_BSUB: r_ff    <= x_ff[MUL_W-1:0] - prod_ff[MUL_W-1:0];
         ST_BFIX: begin
            if (op_ff == OP_MULT) begin
               acc_ff <= fix_val;
            end else begin
               base_ff <= fix_val;
            end
         end
         default: ;
      endcase
      if (shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (load_out) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - POWER_W){1'b0}}, rsp_data_ff};

   `MPU_ASSERT_NEXT(a_accept_folds, req_tvalid && req_tready, state_ff == ST_FOLD, "accept did not start fold")
   `MPU_ASSERT_NOW(a_operands_reduced, state_ff == ST_BIT, (acc_ff < PRIME[POWER_W-1:0]) && (base_ff < PRIME[POWER_W-1:0]), "operand not reduced")
   `MPU_ASSERT_NOW(a_barrett_bound, state_ff == ST_BFIX, r_ff < PRIME_X3, "Barrett remainder out of range")
   `MPU_ASSERT_NOW(a_result_range, rsp_tvalid, rsp_tdata < PRIME, "result not below modulus")

endmodule

FILE: tb/sv/modular_power_unit_test.sv
// ----------------------------------------------------------------------------
// Modular power unit testbench
// A short directed table is sent first: zero exponents, bases that are
// multiples of the prime, field extremes and Fermat identities. Random
// requests follow. Each request's power is typed in or predicted by square
// and multiply and compared with the responses in order. Both sides stall
// in random bursts, except during the final stretch.
// ----------------------------------------------------------------------------
module modular_power_unit_test
   import mpu_pkg::*;
();

   localparam int          RANDOM_REQUESTS = 700;
   localparam int          QUIET_TAIL      = 100;  // final requests sent without idling
   localparam int          WATCHDOG_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES    = 50;
   localparam int          MAX_REPORTS     = 10;
   localparam logic [62:0] FIELD_MAX       = '1;
   localparam logic [62:0] P63             = 63'(PRIME);

   typedef struct packed {
      logic [62:0] base;
      logic [62:0] exponent;
      logic        known;    // power typed in below, else predicted
      logic [29:0] power;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // [62:0] base, [125:63] exponent, rest zero
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;       // [29:0] power, rest zero

   stim_row_type directed_rows[$];
   logic [29:0]  power_q[$];
   bit           no_idle = 1'b0;
   int           errors = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;

   modular_power_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // right-to-left square and multiply; operands stay below 2^30
   function automatic logic [29:0] mod_power(input logic [62:0] base,
                                             input logic [62:0] exponent);
      longint unsigned modulus;
      longint unsigned run;
      longint unsigned acc;
      modulus = longint'(PRIME);
      run = longint'(base) % modulus;
      acc = 1;
      for (int i = 0; i < EXP_BITS; i++) begin
         if (exponent[i])
            acc = (acc * run) % modulus;
         run = (run * run) % modulus;
      end
      return acc[29:0];
   endfunction

   function automatic logic [62:0] rand63();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[62:0];
   endfunction

   function automatic void add_row(input logic [62:0] base, input logic [62:0] exponent,
                                   input logic known, input logic [29:0] power);
      stim_row_type entry;
      entry.base     = base;
      entry.exponent = exponent;
      entry.known    = known;
      entry.power    = power;
      directed_rows.insert(directed_rows.size(), entry);
   endfunction

   task automatic send_request(input logic [62:0] base, input logic [62:0] exponent,
                               input logic [29:0] power);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, exponent, base};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      power_q.insert(power_q.size(), power);
   endtask

   initial begin
      stim_row_type row;
      logic [62:0]  base;
      logic [62:0]  exponent;
      int           len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      //      base             exponent                known  power
      add_row(63'd0,           63'd0,                  1'b1,  30'd1);
      add_row(P63,             63'd0,                  1'b1,  30'd1);
      add_row(FIELD_MAX,       63'd0,                  1'b1,  30'd1);
      add_row(63'd0,           63'd1,                  1'b1,  30'd0);
      add_row(63'd0,           FIELD_MAX,              1'b1,  30'd0);
      add_row(P63,             63'd5,                  1'b1,  30'd0);
      add_row(P63 * 63'd7,     FIELD_MAX,              1'b1,  30'd0);
      add_row(63'd1,           FIELD_MAX,              1'b1,  30'd1);
      add_row(63'd5,           63'd1,                  1'b1,  30'd5);
      add_row(63'd2,           63'd10,                 1'b1,  30'd1024);
      add_row(P63 - 63'd1,     63'd2,                  1'b1,  30'd1);
      add_row(P63 + 63'd3,     63'd1,                  1'b1,  30'd3);
      add_row(63'd3,           P63 - 63'd1,            1'b1,  30'd1);
      add_row(FIELD_MAX,       63'd1,                  1'b0,  30'd0);
      add_row(FIELD_MAX,       FIELD_MAX,              1'b0,  30'd0);
      add_row(63'd3,           63'd1 << 62,            1'b0,  30'd0);
      add_row(63'd2,           63'd30,                 1'b0,  30'd0);
      add_row(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0, 30'd0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.base, row.exponent,
                      row.known ? row.power : mod_power(row.base, row.exponent));
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         no_idle = (n >= RANDOM_REQUESTS - QUIET_TAIL);
         case ($urandom_range(0, 9))
            0:       base = P63 * 63'($urandom_range(0, 1000000));
            1:       base = 63'($urandom_range(0, 3));
            2:       base = P63 + 63'($urandom_range(0, 2)) - 63'd1;
            default: base = rand63();
         endcase
         // mostly short exponents keep the run time down; full length now and then
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(0, 16);
            6, 7:             len = $urandom_range(17, 40);
            default:          len = 63;
         endcase
         exponent = (len == 0) ? 63'd0 : rand63() >> (63 - len);
         send_request(base, exponent, mod_power(base, exponent));
      end
      req_tvalid <= 1'b0;

      while (power_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // response checker, receiver stalls and watchdog
   always @(posedge clock) begin
      logic [29:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            if (rsp_tvalid && rsp_tready) begin
               if (power_q.size() == 0) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("unexpected response: power %0d", rsp_tdata[29:0]);
               end else begin
                  want = power_q.pop_front();
                  if (rsp_tdata[29:0] !== want) begin
                     errors++;
                     if (errors <= MAX_REPORTS)
                        $display("power mismatch: expected %0d, got %0d",
                                 want, rsp_tdata[29:0]);
                  end
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 12) - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

endmodule
